[src/gga_pkg.sv]
package gga_pkg;

   // default sentence length limit, '$' included
   localparam int unsigned MAX_SENTENCE_DEF = 128;

   // characters
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_SOUTH  = 8'h53;
   localparam logic [7:0] CHAR_WEST   = 8'h57;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   // field numbers of the sentence
   localparam logic [3:0] FLD_TIME     = 4'd1;
   localparam logic [3:0] FLD_LAT      = 4'd2;
   localparam logic [3:0] FLD_LAT_HEMI = 4'd3;
   localparam logic [3:0] FLD_LON      = 4'd4;
   localparam logic [3:0] FLD_LON_HEMI = 4'd5;
   localparam logic [3:0] FLD_SATS     = 4'd7;
   localparam logic [3:0] FLD_ALT      = 4'd9;
   localparam logic [3:0] FLD_LAST     = 4'd15;
   localparam logic [3:0] POS_LAST     = 4'd15;

   // saturation limits
   localparam logic [6:0]  SATS_MAX = 7'd99;
   localparam logic [16:0] ALT_MAX  = 17'd99999;

   // shared multiply-add unit
   typedef logic [26:0] mac_a_type;
   typedef logic [24:0] mac_b_type;
   typedef logic [52:0] mac_p_type;

   localparam mac_b_type MUL_TEN     = 25'd10;
   localparam mac_b_type MUL_SIX     = 25'd6;
   localparam mac_b_type MUL_MINUTE  = 25'd1000000;
   localparam mac_b_type MUL_DEGREE  = 25'd10000000;
   // floor(2^27 / 6): quotient estimate is low by at most one
   localparam mac_b_type RECIP_SIX   = 25'd22369621;
   localparam int unsigned RECIP_SHIFT = 27;

   // weight of each fraction digit of the minutes
   function automatic mac_b_type frac_weight(input logic [2:0] idx);
      mac_b_type w;
      unique case (idx)
         3'd0:    w = 25'd100000;
         3'd1:    w = 25'd10000;
         3'd2:    w = 25'd1000;
         3'd3:    w = 25'd100;
         3'd4:    w = 25'd10;
         3'd5:    w = 25'd1;
         default: w = 25'd0;
      endcase
      return w;
   endfunction

   // one result beat, last field in the lowest bits
   typedef struct packed {
      logic signed [17:0] altitude_m;
      logic        [6:0]  satellites;
      logic signed [34:0] longitude;
      logic signed [30:0] latitude;
      logic        [6:0]  utc_seconds;
      logic        [6:0]  utc_minutes;
      logic        [6:0]  utc_hours;
   } rsp_type;

endpackage

[src/nmea_gga_field_parser.sv]
// GGA sentence field parser. Received characters enter one per req_ beat; bytes before a '$'
// are dropped, a '$' starts a sentence and clears all gathered values, commas step the field
// number and a line feed inside a sentence emits one rsp_ beat with UTC hours, minutes and
// seconds, latitude and longitude as signed 1e-7 degree (south and west negative, truncated),
// satellites used (saturating at 99) and the integer altitude in metres (signed, saturating at
// 99999, ended by '.'). Empty fields read as zero, non-digits in numeric positions are skipped,
// and once MAX_SENTENCE-1 bytes of a sentence have been taken further bytes other than '$' and
// line feed are dropped. No checksum or sentence-type check is made. Sequence: a byte is taken
// in the idle state and applied in the byte state, digits by a pass through the single shared
// multiply-add unit that does all digit accumulation; no new byte is taken meanwhile. After a
// closing line feed each coordinate needs four passes of that unit (minutes, reciprocal divide
// by six, correction, degrees); the result is loaded once the previous one has left rsp_.
module nmea_gga_field_parser #(
   parameter int unsigned MAX_SENTENCE = gga_pkg::MAX_SENTENCE_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // rx_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // utc_hours, utc_minutes, utc_seconds, latitude, longitude, satellites, altitude_m
   output logic [111:0] rsp_tdata
);

   localparam int unsigned CNT_W = $clog2(MAX_SENTENCE);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_SENTENCE - 1);

   // sequencer codes
   localparam logic [2:0] ST_IDLE = 3'd0;   // waiting for a byte
   localparam logic [2:0] ST_BYTE = 3'd1;   // apply the byte
   localparam logic [2:0] ST_CV_N = 3'd2;   // minutes * 1e6 + fraction
   localparam logic [2:0] ST_CV_Q = 3'd3;   // quotient estimate by reciprocal
   localparam logic [2:0] ST_CV_R = 3'd4;   // remainder check, quotient fix-up
   localparam logic [2:0] ST_CV_D = 3'd5;   // degrees * 1e7 + quotient
   localparam logic [2:0] ST_FIN  = 3'd6;   // load the result register

   logic [2:0] state_ff, state_in;
   logic [7:0] byte_ff;

   // sentence tracking
   logic             in_sent_ff, in_sent_in;
   logic [3:0]       field_ff, field_in;
   logic [3:0]       pos_ff, pos_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // gathered values
   logic [6:0]  hh_ff, hh_in, mm_ff, mm_in, ss_ff, ss_in;
   logic [9:0]  lat_deg_ff, lat_deg_in, lon_deg_ff, lon_deg_in;
   logic [6:0]  lat_min_ff, lat_min_in, lon_min_ff, lon_min_in;
   logic [19:0] lat_frac_ff, lat_frac_in, lon_frac_ff, lon_frac_in;
   logic        lat_neg_ff, lat_neg_in, lon_neg_ff, lon_neg_in;
   logic [6:0]  sat_ff, sat_in;
   logic [16:0] alt_ff, alt_in;
   logic        alt_neg_ff, alt_neg_in, alt_dot_ff, alt_dot_in;

   // conversion working registers
   logic        which_ff, which_in;   // low: latitude, high: longitude
   logic [26:0] n_ff, n_in;
   logic [24:0] q_ff, q_in;
   logic [29:0] lat_mag_ff, lat_mag_in;
   logic [33:0] lon_mag_ff, lon_mag_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   gga_pkg::rsp_type rsp_ff, rsp_in;

   // shared multiply-add unit
   gga_pkg::mac_a_type mac_a, mac_c;
   gga_pkg::mac_b_type mac_b;
   gga_pkg::mac_p_type mac_p;

   assign mac_p = gga_pkg::mac_p_type'(mac_a) * gga_pkg::mac_p_type'(mac_b)
                + gga_pkg::mac_p_type'(mac_c);

   // byte decode
   logic       is_digit;
   logic [3:0] digit;
   logic       coord_lon;
   logic [3:0] deg_digits;
   logic [3:0] frac_idx;
   logic [3:0] rem;

   assign is_digit   = (byte_ff >= gga_pkg::CHAR_ZERO) && (byte_ff <= gga_pkg::CHAR_NINE);
   assign digit      = is_digit ? 4'(byte_ff - gga_pkg::CHAR_ZERO) : 4'd0;
   assign coord_lon  = (field_ff == gga_pkg::FLD_LON);
   assign deg_digits = coord_lon ? 4'd3 : 4'd2;
   assign frac_idx   = pos_ff - (deg_digits + 4'd3);
   // remainder of n - 6*q0 is below twelve, so four bits carry it exactly
   assign rem        = n_ff[3:0] - mac_p[3:0];

   logic signed [30:0] lat_out;
   logic signed [34:0] lon_out;
   logic signed [17:0] alt_out;

   assign lat_out = lat_neg_ff ? 31'(31'd0 - {1'b0, lat_mag_ff}) : {1'b0, lat_mag_ff};
   assign lon_out = lon_neg_ff ? 35'(35'd0 - {1'b0, lon_mag_ff}) : {1'b0, lon_mag_ff};
   assign alt_out = alt_neg_ff ? 18'(18'd0 - {1'b0, alt_ff}) : {1'b0, alt_ff};

   always_comb begin
      state_in    = state_ff;
      in_sent_in  = in_sent_ff;
      field_in    = field_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      hh_in       = hh_ff;
      mm_in       = mm_ff;
      ss_in       = ss_ff;
      lat_deg_in  = lat_deg_ff;
      lon_deg_in  = lon_deg_ff;
      lat_min_in  = lat_min_ff;
      lon_min_in  = lon_min_ff;
      lat_frac_in = lat_frac_ff;
      lon_frac_in = lon_frac_ff;
      lat_neg_in  = lat_neg_ff;
      lon_neg_in  = lon_neg_ff;
      sat_in      = sat_ff;
      alt_in      = alt_ff;
      alt_neg_in  = alt_neg_ff;
      alt_dot_in  = alt_dot_ff;
      which_in    = which_ff;
      n_in        = n_ff;
      q_in        = q_ff;
      lat_mag_in  = lat_mag_ff;
      lon_mag_in  = lon_mag_ff;
      rsp_in      = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mac_a = '0;
      mac_b = '0;
      mac_c = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_BYTE;
            end
         end

         ST_BYTE: begin
            state_in = ST_IDLE;
            priority if (byte_ff == gga_pkg::CHAR_DOLLAR) begin
               // (re)start: everything gathered so far is dropped
               in_sent_in  = 1'b1;
               field_in    = '0;
               pos_in      = '0;
               count_in    = CNT_W'(1);
               hh_in       = '0;
               mm_in       = '0;
               ss_in       = '0;
               lat_deg_in  = '0;
               lon_deg_in  = '0;
               lat_min_in  = '0;
               lon_min_in  = '0;
               lat_frac_in = '0;
               lon_frac_in = '0;
               lat_neg_in  = 1'b0;
               lon_neg_in  = 1'b0;
               sat_in      = '0;
               alt_in      = '0;
               alt_neg_in  = 1'b0;
               alt_dot_in  = 1'b0;
            end else if (!in_sent_ff) begin
            end else if (byte_ff == gga_pkg::CHAR_LF) begin
               in_sent_in = 1'b0;
               which_in   = 1'b0;
               state_in   = ST_CV_N;
            end else if (count_ff >= CNT_LIMIT) begin
            end else begin
               count_in = count_ff + 1'b1;
               if (byte_ff == gga_pkg::CHAR_COMMA) begin
                  if (field_ff != gga_pkg::FLD_LAST) begin
                     field_in = field_ff + 1'b1;
                  end
                  pos_in = '0;
               end else begin
                  if (pos_ff != gga_pkg::POS_LAST) begin
                     pos_in = pos_ff + 1'b1;
                  end
                  unique case (field_ff)
                     gga_pkg::FLD_TIME: begin
                        if (is_digit && pos_ff < 4'd6) begin
                           mac_b = gga_pkg::MUL_TEN;
                           mac_c = gga_pkg::mac_a_type'(digit);
                           unique case (pos_ff[2:1])
                              2'd0: begin
                                 mac_a = gga_pkg::mac_a_type'(hh_ff);
                                 hh_in = mac_p[6:0];
                              end
                              2'd1: begin
                                 mac_a = gga_pkg::mac_a_type'(mm_ff);
                                 mm_in = mac_p[6:0];
                              end
                              default: begin
                                 mac_a = gga_pkg::mac_a_type'(ss_ff);
                                 ss_in = mac_p[6:0];
                              end
                           endcase
                        end
                     end

                     gga_pkg::FLD_LAT, gga_pkg::FLD_LON: begin
                        if (is_digit) begin
                           priority if (pos_ff < deg_digits) begin
                              mac_a = gga_pkg::mac_a_type'(coord_lon ? lon_deg_ff : lat_deg_ff);
                              mac_b = gga_pkg::MUL_TEN;
                              mac_c = gga_pkg::mac_a_type'(digit);
                              if (coord_lon) begin
                                 lon_deg_in = mac_p[9:0];
                              end else begin
                                 lat_deg_in = mac_p[9:0];
                              end
                           end else if (pos_ff < deg_digits + 4'd2) begin
                              mac_a = gga_pkg::mac_a_type'(coord_lon ? lon_min_ff : lat_min_ff);
                              mac_b = gga_pkg::MUL_TEN;
                              mac_c = gga_pkg::mac_a_type'(digit);
                              if (coord_lon) begin
                                 lon_min_in = mac_p[6:0];
                              end else begin
                                 lat_min_in = mac_p[6:0];
                              end
                           end else if (pos_ff >= deg_digits + 4'd3 &&
                                        pos_ff < deg_digits + 4'd9) begin
                              // fraction digit: weight by its place
                              mac_a = gga_pkg::mac_a_type'(digit);
                              mac_b = gga_pkg::frac_weight(frac_idx[2:0]);
                              mac_c = gga_pkg::mac_a_type'(coord_lon ? lon_frac_ff
                                                                     : lat_frac_ff);
                              if (coord_lon) begin
                                 lon_frac_in = mac_p[19:0];
                              end else begin
                                 lat_frac_in = mac_p[19:0];
                              end
                           end else begin
                           end
                        end
                     end

                     gga_pkg::FLD_LAT_HEMI: begin
                        if (pos_ff == 4'd0 && byte_ff == gga_pkg::CHAR_SOUTH) begin
                           lat_neg_in = 1'b1;
                        end
                     end

                     gga_pkg::FLD_LON_HEMI: begin
                        if (pos_ff == 4'd0 && byte_ff == gga_pkg::CHAR_WEST) begin
                           lon_neg_in = 1'b1;
                        end
                     end

                     gga_pkg::FLD_SATS: begin
                        if (is_digit) begin
                           mac_a  = gga_pkg::mac_a_type'(sat_ff);
                           mac_b  = gga_pkg::MUL_TEN;
                           mac_c  = gga_pkg::mac_a_type'(digit);
                           sat_in = (mac_p[9:0] > 10'(gga_pkg::SATS_MAX)) ? gga_pkg::SATS_MAX
                                                                        : mac_p[6:0];
                        end
                     end

                     gga_pkg::FLD_ALT: begin
                        // sign only at the first place, '.' ends the integer part
                        priority if (pos_ff == 4'd0 && (byte_ff == gga_pkg::CHAR_MINUS ||
                                                        byte_ff == gga_pkg::CHAR_PLUS)) begin
                           if (byte_ff == gga_pkg::CHAR_MINUS) begin
                              alt_neg_in = 1'b1;
                           end
                        end else if (byte_ff == gga_pkg::CHAR_DOT) begin
                           alt_dot_in = 1'b1;
                        end else if (is_digit && !alt_dot_ff) begin
                           mac_a  = gga_pkg::mac_a_type'(alt_ff);
                           mac_b  = gga_pkg::MUL_TEN;
                           mac_c  = gga_pkg::mac_a_type'(digit);
                           alt_in = (mac_p[19:0] > 20'(gga_pkg::ALT_MAX)) ? gga_pkg::ALT_MAX
                                                                        : mac_p[16:0];
                        end else begin
                        end
                     end

                     default: begin
                     end
                  endcase
               end
            end
         end

         ST_CV_N: begin
            mac_a    = gga_pkg::mac_a_type'(which_ff ? lon_min_ff : lat_min_ff);
            mac_b    = gga_pkg::MUL_MINUTE;
            mac_c    = gga_pkg::mac_a_type'(which_ff ? lon_frac_ff : lat_frac_ff);
            n_in     = mac_p[26:0];
            state_in = ST_CV_Q;
         end

         ST_CV_Q: begin
            mac_a    = n_ff;
            mac_b    = gga_pkg::RECIP_SIX;
            q_in     = mac_p[gga_pkg::RECIP_SHIFT +: 25];
            state_in = ST_CV_R;
         end

         ST_CV_R: begin
            mac_a    = gga_pkg::mac_a_type'(q_ff);
            mac_b    = gga_pkg::MUL_SIX;
            q_in     = q_ff + 25'(rem >= 4'd6);
            state_in = ST_CV_D;
         end

         ST_CV_D: begin
            mac_a = gga_pkg::mac_a_type'(which_ff ? lon_deg_ff : lat_deg_ff);
            mac_b = gga_pkg::MUL_DEGREE;
            mac_c = gga_pkg::mac_a_type'(q_ff);
            if (which_ff) begin
               lon_mag_in = mac_p[33:0];
               state_in   = ST_FIN;
            end else begin
               lat_mag_in = mac_p[29:0];
               which_in   = 1'b1;
               state_in   = ST_CV_N;
            end
         end

         ST_FIN: begin
            // wait until the previous record has left
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in.utc_hours   = hh_ff;
               rsp_in.utc_minutes = mm_ff;
               rsp_in.utc_seconds = ss_ff;
               rsp_in.latitude    = lat_out;
               rsp_in.longitude   = lon_out;
               rsp_in.satellites  = sat_ff;
               rsp_in.altitude_m  = alt_out;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_sent_ff   <= 1'b0;
         field_ff     <= '0;
         pos_ff       <= '0;
         count_ff     <= '0;
         which_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_sent_ff   <= in_sent_in;
         field_ff     <= field_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         which_ff     <= which_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset: a '$' clears the values before any record can use them
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         byte_ff <= req_tdata;
      end
      hh_ff       <= hh_in;
      mm_ff       <= mm_in;
      ss_ff       <= ss_in;
      lat_deg_ff  <= lat_deg_in;
      lon_deg_ff  <= lon_deg_in;
      lat_min_ff  <= lat_min_in;
      lon_min_ff  <= lon_min_in;
      lat_frac_ff <= lat_frac_in;
      lon_frac_ff <= lon_frac_in;
      lat_neg_ff  <= lat_neg_in;
      lon_neg_ff  <= lon_neg_in;
      sat_ff      <= sat_in;
      alt_ff      <= alt_in;
      alt_neg_ff  <= alt_neg_in;
      alt_dot_ff  <= alt_dot_in;
      n_ff        <= n_in;
      q_ff        <= q_in;
      lat_mag_ff  <= lat_mag_in;
      lon_mag_ff  <= lon_mag_in;
      rsp_ff      <= rsp_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // a new record only ever appears out of the load step
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FIN)
      else $error("result raised outside the load step");

   // latitude conversion always hands over to longitude
   a_lat_then_lon: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CV_D && !which_ff) |=> (state_ff == ST_CV_N && which_ff))
      else $error("coordinate sequence broken");

   // byte counter never runs past the length limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      in_sent_ff |-> count_ff <= CNT_LIMIT)
      else $error("sentence byte count beyond limit");

   // remainder after the reciprocal estimate stays below twice the divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CV_R |-> rem < 4'd12)
      else $error("divide by six estimate out of range");

endmodule
